>>> src/sqd_pkg.sv
// Shared types and codes for the store queue disambiguation block.
// Used by the entry cells, the top level and the port checker.
`default_nettype none

package sqd_pkg;

  localparam int ADDR_W = 48;
  localparam int TAG_W  = 32;
  localparam int SIZE_W = 7;
  localparam int OCC_W  = 5;

  // operation codes
  localparam logic [2:0] FUNC_INSERT    = 3'd0;
  localparam logic [2:0] FUNC_TRANSLATE = 3'd1;
  localparam logic [2:0] FUNC_COMMIT    = 3'd2;
  localparam logic [2:0] FUNC_RELEASE   = 3'd3;
  localparam logic [2:0] FUNC_LOAD      = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd1;
  localparam logic [2:0] ST_NOT_XLATED   = 3'd2;
  localparam logic [2:0] ST_ALREADY_CMT  = 3'd3;
  localparam logic [2:0] ST_FULL         = 3'd4;

  // load actions
  localparam logic [1:0] ACT_WAIT    = 2'd0;
  localparam logic [1:0] ACT_FORWARD = 2'd1;
  localparam logic [1:0] ACT_FETCH   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_FORWARD_EN = 2'd0;
  localparam logic [1:0] REG_BYPASS_EN  = 2'd1;
  localparam logic [1:0] REG_BUF_LIMIT  = 2'd2;

  typedef struct packed {
    logic [2:0]        func;
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
  } sqd_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             older_store_pending;
    logic [1:0]       load_action;
    logic             buffer_full;
    logic             done_notice;
    logic             update_request;
    logic [OCC_W-1:0] occupancy;
  } sqd_out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              apply;
    logic [2:0]        func;
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W:0]   load_end;
  } sqd_cmd_t;

  // handed from each cell to the next one up the row
  typedef struct packed {
    logic free_found;
    logic match_found;
    logic match_tr;
    logic match_cm;
    logic older;
    logic fwd;
    logic hit;
  } sqd_link_t;

endpackage

`default_nettype wire

>>> src/sqd_cell.sv
// One store queue entry: holds tag, address, size and flags, compares them
// against the broadcast item and passes priority and hit flags to its neighbor.
// Depends on sqd_pkg.
`default_nettype none

module sqd_cell import sqd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  sqd_cmd_t  cmd,
  input  sqd_link_t link_in,
  output sqd_link_t link_out
);

  logic              valid_r, tr_r, cm_r;
  logic [TAG_W-1:0]  tag_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SIZE_W-1:0] size_r;
  logic              match_r, older_r, cov_r, ovl_r;

  logic [ADDR_W:0]   s_start, s_end, l_start;
  logic              nonzero, covers, overlaps;
  logic              sel_free, sel_match;

  always_comb begin
    s_start  = {1'b0, addr_r};
    s_end    = s_start + (ADDR_W+1)'(size_r);
    l_start  = {1'b0, cmd.address};
    nonzero  = (size_r != '0) && (cmd.size != '0);
    covers   = nonzero && (l_start >= s_start) && (cmd.load_end <= s_end);
    overlaps = nonzero && (l_start < s_end) && (s_start < cmd.load_end);
  end

  // compare flags, registered in the cycle after the item is captured
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
      older_r <= 1'b0;
      cov_r   <= 1'b0;
      ovl_r   <= 1'b0;
    end else begin
      match_r <= valid_r && (tag_r == cmd.tag);
      older_r <= valid_r && !tr_r && (tag_r < cmd.tag);
      cov_r   <= valid_r && tr_r && covers;
      ovl_r   <= valid_r && tr_r && overlaps;
    end
  end

  assign sel_free  = !valid_r && !link_in.free_found;
  assign sel_match = match_r && !link_in.match_found;

  always_comb begin
    link_out.free_found  = link_in.free_found | !valid_r;
    link_out.match_found = link_in.match_found | match_r;
    link_out.match_tr    = sel_match ? tr_r : link_in.match_tr;
    link_out.match_cm    = sel_match ? cm_r : link_in.match_cm;
    link_out.older       = link_in.older | older_r;
    link_out.fwd         = link_in.fwd | cov_r;
    link_out.hit         = link_in.hit | ovl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tr_r    <= 1'b0;
      cm_r    <= 1'b0;
    end else if (cmd.apply) begin
      case (cmd.func)
        FUNC_INSERT: begin
          if (sel_free) begin
            valid_r <= 1'b1;
            tr_r    <= 1'b0;
            cm_r    <= 1'b0;
          end
        end
        FUNC_TRANSLATE: begin
          if (sel_match) tr_r <= 1'b1;
        end
        FUNC_COMMIT: begin
          if (sel_match && tr_r) cm_r <= 1'b1;
        end
        FUNC_RELEASE: begin
          if (sel_match) begin
            valid_r <= 1'b0;
            tr_r    <= 1'b0;
            cm_r    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (cmd.func == FUNC_INSERT && sel_free) begin
        tag_r  <= cmd.tag;
        addr_r <= cmd.address;
        size_r <= cmd.size;
      end else if (cmd.func == FUNC_TRANSLATE && sel_match) begin
        addr_r <= cmd.address;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/store_queue_disambiguation_top.sv
// Store queue disambiguation: controller, configuration registers and a row
// of sqd_cell entries. Depends on sqd_pkg and sqd_cell.
//
// Usage:
//   in_*   : one operation per beat (insert, translate, commit, release,
//            load check), sqd_in_t payload on in_data.
//   out_*  : exactly one sqd_out_t result per input beat, in order.
//   cfg_*  : register writes (forward enable, bypass enable, buffer limit),
//            always ready; write only while no operation is in flight.
// Timing: an input beat is captured, the cells compare it against every
//   entry in the next cycle, and the following cycle walks the cell row for
//   first-free / first-match priority; once the output register is free, the
//   block updates the entries and loads the result register. No new beat is
//   taken until that result has been loaded, as in_ready is high only in the
//   idle state.
// The input is accepted while an earlier result still waits in the output
//   register; if the receiver stalls, the next item holds in its apply
//   cycle until the output register frees up.
// Reset: all entries invalid, occupancy zero, forwarding and bypass off,
//   buffer limit 16. No clearing pass is needed.
`default_nettype none

module store_queue_disambiguation_top import sqd_pkg::*; #(
  parameter int STORE_ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sqd_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sqd_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  localparam int CNT_W = $clog2(STORE_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]       state_r, state_nxt;
  sqd_in_t          item_r;
  logic [ADDR_W:0]  load_end_r;
  logic             fwd_en_r, byp_en_r;
  logic [4:0]       limit_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;
  sqd_out_t         out_data_r, result;
  logic             fire;
  sqd_cmd_t         cmd;
  sqd_link_t        links [0:STORE_ENTRIES];
  sqd_link_t        tail;
  logic [CMP_W-1:0] cnt_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign fire = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = S_APPLY;
      S_APPLY: if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // capture the item and the end of the load interval
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r     <= in_data;
      load_end_r <= {1'b0, in_data.address} + (ADDR_W+1)'(in_data.size);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_en_r <= 1'b0;
      byp_en_r <= 1'b0;
      limit_r  <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FORWARD_EN: fwd_en_r <= cfg_data[0];
        REG_BYPASS_EN:  byp_en_r <= cfg_data[0];
        REG_BUF_LIMIT:  limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd.apply    = fire;
    cmd.func     = item_r.func;
    cmd.tag      = item_r.tag;
    cmd.address  = item_r.address;
    cmd.size     = item_r.size;
    cmd.load_end = load_end_r;
  end

  assign links[0] = '0;

  genvar g;
  generate
    for (g = 0; g < STORE_ENTRIES; g++) begin : g_cell
      sqd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .link_in  (links[g]),
        .link_out (links[g+1])
      );
    end
  endgenerate

  assign tail = links[STORE_ENTRIES];

  always_comb begin
    result  = '0;
    cnt_nxt = cnt_r;
    case (item_r.func)
      FUNC_INSERT: begin
        if (!tail.free_found) result.status = ST_FULL;
      end
      FUNC_TRANSLATE: begin
        if (!tail.match_found) begin
          result.status = ST_NOT_FOUND;
        end else begin
          result.done_notice = 1'b1;
          if (!tail.match_tr) cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      FUNC_COMMIT: begin
        if (!tail.match_found)   result.status = ST_NOT_FOUND;
        else if (!tail.match_tr) result.status = ST_NOT_XLATED;
        else if (tail.match_cm)  result.status = ST_ALREADY_CMT;
        else                     result.update_request = 1'b1;
      end
      FUNC_RELEASE: begin
        if (!tail.match_found) begin
          result.status = ST_NOT_FOUND;
        end else if (tail.match_tr && cnt_r != '0) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      FUNC_LOAD: begin
        result.older_store_pending = tail.older;
        if (tail.older)                           result.load_action = ACT_WAIT;
        else if (tail.fwd && fwd_en_r)            result.load_action = ACT_FORWARD;
        else if (cnt_r == '0 || (byp_en_r && !tail.hit))
                                                  result.load_action = ACT_FETCH;
        else                                      result.load_action = ACT_WAIT;
      end
      default: ;
    endcase
    cnt_ext            = CMP_W'(cnt_nxt);
    result.buffer_full = (cnt_ext >= CMP_W'(limit_r));
    result.occupancy   = cnt_ext[OCC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)    cnt_r <= '0;
    else if (fire) cnt_r <= cnt_nxt;
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data_r <= result;
  end

endmodule

`default_nettype wire

>>> src/sqd_checker.sv
// Port-level checks for the store queue disambiguation top level, bound in
// below. Depends on sqd_pkg.
`default_nettype none

module sqd_checker import sqd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input sqd_out_t   out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one item in flight: ready drops after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in flight");

  // a pending older store always forces wait
  a_older_waits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.older_store_pending |-> out_data.load_action == ACT_WAIT)
    else $error("load proceeds past an untranslated older store");

  // notices only come with a clean status
  a_notice_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.done_notice || out_data.update_request)
      |-> out_data.status == ST_OK)
    else $error("notice raised on a failed operation");

endmodule

bind store_queue_disambiguation_top sqd_checker u_sqd_checker (.*);

`default_nettype wire

>>> bench/sqd_result_checker.sv
// Result checker for the store queue disambiguation block: watches the input,
// result and register-write channels, predicts every result and compares it.
// Depends on sqd_pkg for the payload types, operation and status codes.

module sqd_result_checker import sqd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  sqd_in_t    in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  sqd_out_t   out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  output int         error_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the store table and registers
  bit                fwd_en;
  bit                byp_en;
  logic [OCC_W-1:0]  buf_limit;
  bit                sq_live      [DEPTH];
  logic [TAG_W-1:0]  sq_tag       [DEPTH];
  logic [ADDR_W-1:0] sq_addr      [DEPTH];
  logic [SIZE_W-1:0] sq_len       [DEPTH];
  bit                sq_xlated    [DEPTH];
  bit                sq_committed [DEPTH];
  logic [OCC_W-1:0]  xlated_count;

  sqd_out_t expected_results[$];
  sqd_out_t want;
  int       result_num;

  initial begin
    error_count = 0;
    pending     = 0;
    result_num  = 0;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp_val);
    error_count++;
    if (error_count <= 100)
      $display("%0t ns: result %0d %s: got %0d, expected %0d",
               $time, result_num, what, got, exp_val);
  endtask

  function automatic int find_store(logic [TAG_W-1:0] t);
    for (int i = 0; i < DEPTH; i++)
      if (sq_live[i] && sq_tag[i] == t) return i;
    return -1;
  endfunction

  // byte ranges [a, a+n) and [b, b+m), no wrap at the top of the address space
  function automatic bit spans_overlap(logic [63:0] a, int unsigned n,
                                       logic [63:0] b, int unsigned m);
    if (n == 0 || m == 0) return 1'b0;
    if (a >= b) return (a - b) < 64'(m);
    return (b - a) < 64'(n);
  endfunction

  function automatic bit store_covers_load(logic [63:0] s, int unsigned m,
                                           logic [63:0] l, int unsigned n);
    logic [63:0] off;
    if (n == 0 || m == 0 || l < s) return 1'b0;
    off = l - s;
    if (off > 64'(m)) return 1'b0;
    return 64'(n) <= 64'(m) - off;
  endfunction

  // apply one operation to the shadow table and return the result it gives
  function automatic sqd_out_t next_store_queue_result(sqd_in_t op);
    sqd_out_t r;
    int       k;
    bit       older;
    bit       fwd;
    bit       hit;
    r     = '0;
    k     = -1;
    older = 1'b0;
    fwd   = 1'b0;
    hit   = 1'b0;
    case (op.func)
      FUNC_INSERT: begin
        for (int i = 0; i < DEPTH; i++)
          if (k < 0 && !sq_live[i]) k = i;
        if (k < 0) begin
          r.status = ST_FULL;
        end else begin
          sq_live[k]      = 1'b1;
          sq_tag[k]       = op.tag;
          sq_addr[k]      = op.address;
          sq_len[k]       = op.size;
          sq_xlated[k]    = 1'b0;
          sq_committed[k] = 1'b0;
        end
      end
      FUNC_TRANSLATE: begin
        k = find_store(op.tag);
        if (k < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          sq_addr[k] = op.address;
          if (!sq_xlated[k]) begin
            sq_xlated[k] = 1'b1;
            xlated_count++;
          end
          r.done_notice = 1'b1;
        end
      end
      FUNC_COMMIT: begin
        k = find_store(op.tag);
        if (k < 0) r.status = ST_NOT_FOUND;
        else if (!sq_xlated[k]) r.status = ST_NOT_XLATED;
        else if (sq_committed[k]) r.status = ST_ALREADY_CMT;
        else begin
          sq_committed[k]  = 1'b1;
          r.update_request = 1'b1;
        end
      end
      FUNC_RELEASE: begin
        k = find_store(op.tag);
        if (k < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          if (sq_xlated[k] && xlated_count != 0) xlated_count--;
          sq_live[k]      = 1'b0;
          sq_xlated[k]    = 1'b0;
          sq_committed[k] = 1'b0;
        end
      end
      FUNC_LOAD: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (sq_live[i] && !sq_xlated[i]) begin
            if (sq_tag[i] < op.tag) older = 1'b1;
          end else if (sq_live[i]) begin
            if (store_covers_load(64'(sq_addr[i]), sq_len[i], 64'(op.address), op.size))
              fwd = 1'b1;
            if (spans_overlap(64'(op.address), op.size, 64'(sq_addr[i]), sq_len[i]))
              hit = 1'b1;
          end
        end
        r.older_store_pending = older;
        if (older) r.load_action = ACT_WAIT;
        else if (fwd && fwd_en) r.load_action = ACT_FORWARD;
        else if (xlated_count == 0 || (byp_en && !hit)) r.load_action = ACT_FETCH;
        else r.load_action = ACT_WAIT;
      end
      default: ;
    endcase
    r.buffer_full = (xlated_count >= buf_limit);
    r.occupancy   = xlated_count;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fwd_en       = 1'b0;
      byp_en       = 1'b0;
      buf_limit    = 5'd16;
      xlated_count = '0;
      for (int i = 0; i < DEPTH; i++) begin
        sq_live[i]      = 1'b0;
        sq_xlated[i]    = 1'b0;
        sq_committed[i] = 1'b0;
      end
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FORWARD_EN: fwd_en = cfg_data[0];
          REG_BYPASS_EN:  byp_en = cfg_data[0];
          REG_BUF_LIMIT:  buf_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_results.push_back(next_store_queue_result(in_data));
      if (out_valid && out_ready) begin
        result_num++;
        if (expected_results.size() == 0) begin
          report_mismatch("beat with nothing expected", out_data, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.older_store_pending !== want.older_store_pending)
            report_mismatch("older_store_pending", out_data.older_store_pending,
                            want.older_store_pending);
          if (out_data.load_action !== want.load_action)
            report_mismatch("load_action", out_data.load_action, want.load_action);
          if (out_data.buffer_full !== want.buffer_full)
            report_mismatch("buffer_full", out_data.buffer_full, want.buffer_full);
          if (out_data.done_notice !== want.done_notice)
            report_mismatch("done_notice", out_data.done_notice, want.done_notice);
          if (out_data.update_request !== want.update_request)
            report_mismatch("update_request", out_data.update_request,
                            want.update_request);
          if (out_data.occupancy !== want.occupancy)
            report_mismatch("occupancy", out_data.occupancy, want.occupancy);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> bench/store_queue_disambiguation_top_test.sv
// Top of the store queue disambiguation test: clock, reset, operation and
// register-write stimulus, receiver stalls and the final verdict.
// Depends on sqd_pkg, store_queue_disambiguation_top and sqd_result_checker.

module store_queue_disambiguation_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sqd_pkg::*;

  localparam int STORE_DEPTH = 16;
  localparam int PHASE_ITEMS = 500;
  localparam int HOLD_CYCLES = 200;
  // func codes the block ignores
  localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

  typedef struct {
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] paddr;
    logic [SIZE_W-1:0] len;
    bit                xl;
  } store_note_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  sqd_in_t    in_data;
  logic       out_valid;
  logic       out_ready;
  sqd_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;
  int         error_count;
  int         pending;

  int                idle_pct  = 0;
  int                stall_pct = 0;
  bit                hold_go   = 1'b0;
  logic [TAG_W-1:0]  age       = 32'd100;
  logic [ADDR_W-1:0] win_base  = 48'h0000_0000_1000;
  store_note_t       live_stores[$];

  store_queue_disambiguation_top #(.STORE_ENTRIES(STORE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sqd_result_checker #(.DEPTH(STORE_DEPTH)) results_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: one long hold-off once asked for, then random stalls
  initial begin : receiver
    int held;
    held = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && held < HOLD_CYCLES) begin
        out_ready <= 1'b0;
        held++;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic sqd_in_t op_of(logic [2:0] f, logic [TAG_W-1:0] t,
                                    logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s);
    sqd_in_t op;
    op.func    = f;
    op.tag     = t;
    op.address = a;
    op.size    = s;
    return op;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ADDR_W-1:0] win_addr();
    return win_base + ADDR_W'($urandom_range(0, 255));
  endfunction

  // mostly well-formed store lifetimes on tracked tags, some noise
  function automatic sqd_in_t make_random_op();
    sqd_in_t     op;
    store_note_t e;
    int          pick;
    int          j;
    int          off;
    pick       = $urandom_range(0, 99);
    op.func    = FUNC_LOAD;
    op.tag     = $urandom;
    op.address = rand_addr();
    op.size    = $urandom_range(0, 127);
    if (pick < 4) begin
      op.func = 3'($urandom_range(0, 7));
      return op;
    end
    if (live_stores.size() == 0 || pick < (live_stores.size() >= STORE_DEPTH ? 10 : 30)) begin
      age     = age + $urandom_range(1, 3);
      op.func = FUNC_INSERT;
      op.tag  = age;
      if ($urandom_range(0, 7) != 0) op.size = $urandom_range(1, 64);
      if (live_stores.size() < 24) live_stores.push_back('{age, op.address, op.size, 1'b0});
      return op;
    end
    j      = $urandom_range(0, live_stores.size() - 1);
    e      = live_stores[j];
    op.tag = ($urandom_range(0, 15) == 0) ? $urandom : e.tag;
    if (pick < 50) begin
      op.func    = FUNC_TRANSLATE;
      op.address = win_addr();
      if (op.tag == e.tag) begin
        live_stores[j].paddr = op.address;
        live_stores[j].xl    = 1'b1;
      end
    end else if (pick < 60) begin
      op.func = FUNC_COMMIT;
    end else if (pick < 72) begin
      op.func = FUNC_RELEASE;
      if (op.tag == e.tag) live_stores.delete(j);
    end else begin
      case ($urandom_range(0, 3))
        0: op.tag = e.tag;
        1: op.tag = $urandom_range(0, 64);
        2: op.tag = age + 1;
        default: ;
      endcase
      off        = $urandom_range(0, e.len + 8) - 4;
      op.address = e.xl ? e.paddr + ADDR_W'(off) : win_addr();
      if ($urandom_range(0, 7) != 0) op.size = $urandom_range(1, 16);
    end
    return op;
  endfunction

  task automatic send_op(sqd_in_t op);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every expected result has come back
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending != 0 && waited < 20000);
    @(posedge clk);
  endtask

  task automatic program_regs(bit fwd, bit byp, logic [4:0] lim);
    cfg_valid <= 1'b1;
    for (int r = 0; r < 3; r++) begin
      case (r)
        0: begin
          cfg_index <= REG_FORWARD_EN;
          cfg_data  <= {4'($urandom_range(0, 15)), fwd};
        end
        1: begin
          cfg_index <= REG_BYPASS_EN;
          cfg_data  <= {4'($urandom_range(0, 15)), byp};
        end
        default: begin
          cfg_index <= REG_BUF_LIMIT;
          cfg_data  <= lim;
        end
      endcase
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FORWARD_EN;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, forwarding and bypass off, limit 16
    send_op(op_of(FUNC_LOAD, 32'd7, 48'h2000, 7'd8));          // empty table
    send_op(op_of(FUNC_TRANSLATE, 32'd9, 48'h2000, 7'd8));
    send_op(op_of(FUNC_COMMIT, 32'd9, 48'h0, 7'd0));
    send_op(op_of(FUNC_RELEASE, 32'd9, 48'h0, 7'd0));
    send_op(op_of(FUNC_INSERT, 32'h0, 48'hFFFF_FFFF_FFFF, 7'd127));
    send_op(op_of(FUNC_INSERT, 32'hFFFF_FFFF, 48'h0, 7'd64));
    send_op(op_of(FUNC_INSERT, 32'd20, 48'h5555_AAAA_5555, 7'd8));
    send_op(op_of(FUNC_LOAD, 32'd21, 48'h3000, 7'd4));          // older store pending
    send_op(op_of(FUNC_COMMIT, 32'd20, 48'h0, 7'd0));           // not yet translated
    send_op(op_of(FUNC_TRANSLATE, 32'd20, 48'h3000, 7'd0));
    send_op(op_of(FUNC_TRANSLATE, 32'd20, 48'h3000, 7'd0));     // translated twice
    send_op(op_of(FUNC_COMMIT, 32'd20, 48'h0, 7'd0));
    send_op(op_of(FUNC_COMMIT, 32'd20, 48'h0, 7'd0));           // already committed
    send_op(op_of(FUNC_LOAD, 32'd0, 48'h3002, 7'd4));
    send_op(op_of(FUNC_TRANSLATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFC0, 7'd0));
    send_op(op_of(FUNC_LOAD, 32'd0, 48'hFFFF_FFFF_FFFF, 7'd127)); // runs past the top
    send_op(op_of(FUNC_LOAD, 32'd0, 48'h3000, 7'd0));           // zero-size load
    send_op(op_of(FUNC_UNUSED_LO, 32'd20, 48'h3000, 7'd4));
    send_op(op_of(FUNC_UNUSED_HI, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 7'd127));
    send_op(op_of(FUNC_INSERT, 32'd20, 48'h4000, 7'd16));       // duplicate tag
    send_op(op_of(FUNC_RELEASE, 32'd20, 48'h0, 7'd0));          // translated copy first
    send_op(op_of(FUNC_RELEASE, 32'd20, 48'h0, 7'd0));
    send_op(op_of(FUNC_RELEASE, 32'h0, 48'h0, 7'd0));
    send_op(op_of(FUNC_RELEASE, 32'hFFFF_FFFF, 48'h0, 7'd0));

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          program_regs(1'b1, 1'b1, 5'd16);
          idle_pct  = 0;
          stall_pct = 0;
          hold_go   = 1'b1;
        end
        1: begin
          program_regs(1'b0, 1'b1, 5'd1);
          win_base  = 48'hFFFF_FFFF_FF80;
          idle_pct  = 63;
          stall_pct = 0;
        end
        2: begin
          program_regs(1'b1, 1'b0, 5'd0);
          win_base  = rand_addr();
          idle_pct  = 0;
          stall_pct = 63;
        end
        default: begin
          program_regs($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(1, 16));
          win_base  = rand_addr();
          idle_pct  = 29;
          stall_pct = 29;
        end
      endcase
      repeat (PHASE_ITEMS) send_op(make_random_op());
    end

    settle();
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
src/sqd_pkg.sv
src/sqd_cell.sv
src/store_queue_disambiguation_top.sv
src/sqd_checker.sv
bench/sqd_result_checker.sv
bench/store_queue_disambiguation_top_test.sv
